// File: design/pli2c_pkg.sv
// ----------------------------------------------------------------------------
// pli2c_pkg
// Shared types and constants for the parallel-lane I2C write master.
// ----------------------------------------------------------------------------
`default_nettype none

package pli2c_pkg;

    localparam int LANE_COUNT  = 8;
    localparam int SHOWN_LANES = 8;
    localparam int BYTE_BITS   = 8;

    localparam logic [SHOWN_LANES-1:0] LANE_MASK =
        (LANE_COUNT >= SHOWN_LANES) ? {SHOWN_LANES{1'b1}}
                                    : SHOWN_LANES'((1 << LANE_COUNT) - 1);

    localparam logic [2:0] OP_IDLE_HIGH   = 3'd0;
    localparam logic [2:0] OP_START       = 3'd1;
    localparam logic [2:0] OP_STOP        = 3'd2;
    localparam logic [2:0] OP_ACK_CLOCK   = 3'd3;
    localparam logic [2:0] OP_SEND_COMMON = 3'd4;
    localparam logic [2:0] OP_SEND_LANES  = 3'd5;

    typedef logic [SHOWN_LANES-1:0][BYTE_BITS-1:0] lane_bytes_t;

    typedef enum logic [2:0] {
        ACT_DATA_ONES = 3'd0,
        ACT_DATA_ZERO = 3'd1,
        ACT_DATA_BITS = 3'd2,
        ACT_CLK_HIGH  = 3'd3,
        ACT_CLK_LOW   = 3'd4
    } act_t;

    typedef struct packed {
        logic load;
        logic sel_common;
        logic step;
        act_t act;
        logic last;
    } cmd_t;

endpackage

`default_nettype wire

// File: design/pli2c_ctrl.sv
// ----------------------------------------------------------------------------
// pli2c_ctrl
// Command sequencer: walks the pin-state steps of one request.
// ----------------------------------------------------------------------------
`default_nettype none

module pli2c_ctrl
    import pli2c_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [2:0] s_opcode,
    input  wire logic       out_free,
    output cmd_t            cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t      state_reg, state_next;
    logic [2:0]  op_reg, op_next;
    logic [1:0]  ph_reg, ph_next;
    logic [2:0]  bit_reg, bit_next;
    logic        accept;
    logic        op_known;
    logic        byte_op;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign op_known = (s_opcode <= OP_SEND_LANES);
    assign byte_op  = (op_reg == OP_SEND_COMMON) || (op_reg == OP_SEND_LANES);

    always_comb begin
        cmd            = '0;
        cmd.act        = ACT_DATA_ONES;
        cmd.load       = accept;
        cmd.sel_common = (s_opcode == OP_SEND_COMMON);
        cmd.step       = (state_reg == ST_RUN) && out_free;
        unique case (op_reg) inside
            OP_IDLE_HIGH: begin
                cmd.act  = (ph_reg == 2'd0) ? ACT_DATA_ONES : ACT_CLK_HIGH;
                cmd.last = (ph_reg == 2'd1);
            end
            OP_START: begin
                cmd.act  = (ph_reg == 2'd0) ? ACT_DATA_ZERO : ACT_CLK_LOW;
                cmd.last = (ph_reg == 2'd1);
            end
            OP_STOP: begin
                cmd.act  = (ph_reg == 2'd0) ? ACT_DATA_ZERO :
                           (ph_reg == 2'd1) ? ACT_CLK_HIGH  : ACT_DATA_ONES;
                cmd.last = (ph_reg == 2'd2);
            end
            OP_ACK_CLOCK: begin
                cmd.act  = (ph_reg == 2'd0) ? ACT_CLK_HIGH : ACT_CLK_LOW;
                cmd.last = (ph_reg == 2'd1);
            end
            OP_SEND_COMMON, OP_SEND_LANES: begin
                cmd.act  = (ph_reg == 2'd0) ? ACT_DATA_BITS :
                           (ph_reg == 2'd1) ? ACT_CLK_HIGH  : ACT_CLK_LOW;
                cmd.last = (ph_reg == 2'd2) && (bit_reg == 3'd7);
            end
            default: begin
                cmd.act  = ACT_DATA_ONES;
                cmd.last = 1'b1;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        ph_next    = ph_reg;
        bit_next   = bit_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && op_known) begin
                    state_next = ST_RUN;
                    op_next    = s_opcode;
                    ph_next    = 2'd0;
                    bit_next   = 3'd0;
                end
            end
            ST_RUN: begin
                if (cmd.step) begin
                    if (cmd.last) begin
                        state_next = ST_IDLE;
                    end else if (byte_op && (ph_reg == 2'd2)) begin
                        ph_next  = 2'd0;
                        bit_next = bit_reg + 3'd1;
                    end else begin
                        ph_next = ph_reg + 2'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_IDLE_HIGH;
            ph_reg    <= 2'd0;
            bit_reg   <= 3'd0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            ph_reg    <= ph_next;
            bit_reg   <= bit_next;
        end
    end

endmodule

`default_nettype wire

// File: design/pli2c_dp.sv
// ----------------------------------------------------------------------------
// pli2c_dp
// Pin datapath: lane shift registers, SCL/SDA levels and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pli2c_dp
    import pli2c_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire cmd_t                   cmd,
    input  wire logic [BYTE_BITS-1:0]   common_byte,
    input  wire lane_bytes_t            lane_bytes,
    output logic                        out_free,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic                        m_clock_line,
    output logic [SHOWN_LANES-1:0]      m_data_lines,
    output logic                        m_last_step
);

    lane_bytes_t                sr_reg, sr_next;
    logic [SHOWN_LANES-1:0]     data_reg, data_next;
    logic                       clk_reg, clk_next;
    logic                       valid_reg;
    logic [SHOWN_LANES-1:0]     pins;

    assign out_free = !valid_reg || m_ready;
    assign m_valid  = valid_reg;

    always_comb begin
        sr_next = sr_reg;
        for (int i = 0; i < SHOWN_LANES; i++) begin
            pins[i] = sr_reg[i][BYTE_BITS-1];
        end
        if (cmd.load) begin
            for (int i = 0; i < SHOWN_LANES; i++) begin
                sr_next[i] = cmd.sel_common ? common_byte : lane_bytes[i];
            end
        end else if (cmd.step && (cmd.act == ACT_DATA_BITS)) begin
            for (int i = 0; i < SHOWN_LANES; i++) begin
                sr_next[i] = {sr_reg[i][BYTE_BITS-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        data_next = data_reg;
        clk_next  = clk_reg;
        unique case (cmd.act)
            ACT_DATA_ONES: data_next = LANE_MASK;
            ACT_DATA_ZERO: data_next = '0;
            ACT_DATA_BITS: data_next = pins & LANE_MASK;
            ACT_CLK_HIGH:  clk_next  = 1'b1;
            ACT_CLK_LOW:   clk_next  = 1'b0;
            default:       data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        sr_reg <= sr_next;
        if (cmd.step) begin
            m_clock_line <= clk_next;
            m_data_lines <= data_next;
            m_last_step  <= cmd.last;
        end
        if (!aresetn) begin
            data_reg  <= LANE_MASK;
            clk_reg   <= 1'b1;
            valid_reg <= 1'b0;
        end else begin
            if (cmd.step) begin
                data_reg  <= data_next;
                clk_reg   <= clk_next;
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// File: design/parallel_lane_i2c_write_master.sv
// ----------------------------------------------------------------------------
// parallel_lane_i2c_write_master
// Write-only I2C master with eight parallel SDA lanes and one shared SCL.
// ----------------------------------------------------------------------------
// Each request yields a run of pin states on the m_ channel, one per cycle
// while m_ready is held: idle-high, start and ack clock give 2, stop gives 3,
// a byte send gives 24 (data, SCL high, SCL low per bit, MSB first). A request
// is taken when the sequencer is idle, so it waits until the previous request
// has issued its last pin state; opcodes 6 and 7 are taken and give nothing.
// SCL and SDA levels persist between requests and reset to all high.
`default_nettype none

module parallel_lane_i2c_write_master
    import pli2c_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [2:0]           s_opcode,
    input  wire logic [7:0]           s_common_byte,
    input  wire logic [7:0]           s_lane_byte_0,
    input  wire logic [7:0]           s_lane_byte_1,
    input  wire logic [7:0]           s_lane_byte_2,
    input  wire logic [7:0]           s_lane_byte_3,
    input  wire logic [7:0]           s_lane_byte_4,
    input  wire logic [7:0]           s_lane_byte_5,
    input  wire logic [7:0]           s_lane_byte_6,
    input  wire logic [7:0]           s_lane_byte_7,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_clock_line,
    output logic [7:0]                m_data_lines,
    output logic                      m_last_step
);

    cmd_t        cmd;
    logic        out_free;
    lane_bytes_t lane_bytes;

    assign lane_bytes = {s_lane_byte_7, s_lane_byte_6, s_lane_byte_5, s_lane_byte_4,
                         s_lane_byte_3, s_lane_byte_2, s_lane_byte_1, s_lane_byte_0};

    pli2c_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_opcode),
        .out_free (out_free),
        .cmd      (cmd)
    );

    pli2c_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .common_byte  (s_common_byte),
        .lane_bytes   (lane_bytes),
        .out_free     (out_free),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_clock_line (m_clock_line),
        .m_data_lines (m_data_lines),
        .m_last_step  (m_last_step)
    );

    a_step_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> (!m_valid || m_ready))
        else $error("pin state issued while output register full");

    a_busy_after_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_opcode <= OP_SEND_LANES)) |=> !s_ready)
        else $error("request taken while previous one still running");

    a_dead_lanes_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data_lines & ~LANE_MASK) == '0))
        else $error("absent lane driven high");

endmodule

`default_nettype wire
